[sv/lbcs_pkg.sv]
// ----------------------------------------------------------------------------
// LED blink-code sequencer package
// Shared widths, codes, register defaults and the result record.
// ----------------------------------------------------------------------------
package lbcs_pkg;

    // Width of the elapsed-time counter (range 8 to 32).
    localparam int TIMER_BITS = 16;
    localparam int TIME_W     = 16;
    localparam int COUNT_W    = 4;
    // Common width for comparing the elapsed count against a time register.
    localparam int CMP_W      = (TIMER_BITS > TIME_W) ? TIMER_BITS : TIME_W;

    // Phase codes.
    localparam logic [1:0] PH_ON    = 2'd0;
    localparam logic [1:0] PH_GAP   = 2'd1;
    localparam logic [1:0] PH_PAUSE = 2'd2;

    // Step codes.
    localparam logic [1:0] STEP_ZERO = 2'd0;
    localparam logic [1:0] STEP_ONE  = 2'd1;
    localparam logic [1:0] STEP_TWO  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINKS_0   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINKS_1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINKS_2   = 3'd5;

    // Register reset values.
    localparam logic [TIME_W-1:0]  RST_ON_TIME    = 16'd200;
    localparam logic [TIME_W-1:0]  RST_GAP_TIME   = 16'd200;
    localparam logic [TIME_W-1:0]  RST_PAUSE_TIME = 16'd1000;
    localparam logic [COUNT_W-1:0] RST_BLINKS_0   = 4'd1;
    localparam logic [COUNT_W-1:0] RST_BLINKS_1   = 4'd2;
    localparam logic [COUNT_W-1:0] RST_BLINKS_2   = 4'd3;

    // Stream data widths (whole bytes for the input and output streams).
    localparam int IN_DATA_W  = 8;
    localparam int RES_W      = 9;
    localparam int OUT_DATA_W = 16;

    // Result record; the last member sits in the lowest bit.
    typedef struct packed {
        logic [COUNT_W-1:0] blinks_done;
        logic [1:0]         group_step;
        logic [1:0]         phase_now;
        logic               led_on;
    } t_result;

endpackage

[sv/led_blink_count_sequencer.sv]
// ----------------------------------------------------------------------------
// LED blink-code sequencer
// Drives an LED through three repeating groups of blinks from millisecond ticks.
// ----------------------------------------------------------------------------
// Each input transaction is either one millisecond tick (restart bit 0) or a
// restart request (restart bit 1), and each one yields exactly one result
// transaction carrying the LED level, the phase (on, gap, pause), the group
// step and the blinks done so far in the group. The block takes one
// transaction per clock cycle: the whole sequencer step is a few compares and
// counter updates done in the cycle of acceptance, and the result is written to
// the output register or the skid entry. A result register plus one skid
// entry lets the input keep flowing while a result waits; the input stalls
// only when both are full. Configuration registers are written through the
// cfg channel, which is always ready, and should only be written while the
// block is idle. A restart clears the sequence but keeps the registers.
module led_blink_count_sequencer import lbcs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [TIME_W-1:0]     i_cfg_data,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [0] restart, rest zero
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [0] led_on, [2:1] phase_now,
                                                 // [4:3] group_step,
                                                 // [8:5] blinks_done, rest zero
);

    t_result core_result;
    t_result buf_result;
    logic    in_fire;

    assign o_cfg_ready = 1'b1;
    assign in_fire     = s_axis_tvalid && s_axis_tready;

    // Sequencer state advances exactly on accepted transactions.
    lbcs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (in_fire),
        .i_restart   (s_axis_tdata[0]),
        .o_result    (core_result)
    );

    // The buffer decides readiness; its accept matches in_fire above.
    lbcs_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (core_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (buf_result)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-RES_W){1'b0}}, buf_result};

endmodule

[sv/lbcs_core.sv]
// ----------------------------------------------------------------------------
// LED blink-code sequencer core
// Configuration registers and the sequence state, advanced once per accepted tick or restart.
// ----------------------------------------------------------------------------
module lbcs_core import lbcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data,
    input  logic                 i_step,
    input  logic                 i_restart,
    output t_result              o_result
);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [COUNT_W-1:0]    COUNT_MAX = {COUNT_W{1'b1}};

    logic [TIME_W-1:0]     r_on_time, r_gap_time, r_pause_time;
    logic [COUNT_W-1:0]    r_blinks_0, r_blinks_1, r_blinks_2;

    logic [1:0]            r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_elapsed, n_elapsed;
    logic [COUNT_W-1:0]    r_blinks, n_blinks;
    logic [1:0]            r_step, n_step;
    // The LED level is fully set by each step, so it needs no register here.
    logic                  n_led;

    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]      elapsed_cmp;
    logic [COUNT_W-1:0]    blinks_inc;
    logic [COUNT_W-1:0]    group_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_time    <= RST_ON_TIME;
            r_gap_time   <= RST_GAP_TIME;
            r_pause_time <= RST_PAUSE_TIME;
            r_blinks_0   <= RST_BLINKS_0;
            r_blinks_1   <= RST_BLINKS_1;
            r_blinks_2   <= RST_BLINKS_2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ON_TIME:    r_on_time    <= i_cfg_data;
                CFG_GAP_TIME:   r_gap_time   <= i_cfg_data;
                CFG_PAUSE_TIME: r_pause_time <= i_cfg_data;
                CFG_BLINKS_0:   r_blinks_0   <= i_cfg_data[COUNT_W-1:0];
                CFG_BLINKS_1:   r_blinks_1   <= i_cfg_data[COUNT_W-1:0];
                CFG_BLINKS_2:   r_blinks_2   <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_step)
            STEP_ONE: group_count = r_blinks_1;
            STEP_TWO: group_count = r_blinks_2;
            default:  group_count = r_blinks_0;
        endcase
    end

    assign elapsed_inc = (r_elapsed == TIMER_MAX) ? r_elapsed
                                                  : r_elapsed + TIMER_BITS'(1);
    assign elapsed_cmp = CMP_W'(elapsed_inc);
    assign blinks_inc  = (r_blinks == COUNT_MAX) ? r_blinks : r_blinks + COUNT_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = elapsed_inc;
        n_blinks  = r_blinks;
        n_step    = r_step;
        n_led     = 1'b0;
        if (i_restart) begin
            n_phase   = PH_ON;
            n_elapsed = '0;
            n_blinks  = '0;
            n_step    = STEP_ZERO;
        end else begin
            case (r_phase)
                PH_ON: begin
                    n_led = 1'b1;
                    if (elapsed_cmp >= CMP_W'(r_on_time)) begin
                        n_led     = 1'b0;
                        n_blinks  = blinks_inc;
                        n_elapsed = '0;
                        n_phase   = (blinks_inc >= group_count) ? PH_PAUSE : PH_GAP;
                    end
                end
                PH_GAP: begin
                    if (elapsed_cmp >= CMP_W'(r_gap_time)) begin
                        n_phase   = PH_ON;
                        n_elapsed = '0;
                        n_led     = 1'b1;
                    end
                end
                default: begin
                    // Pause, and the unused code that behaves like it.
                    n_phase = PH_PAUSE;
                    if (elapsed_cmp >= CMP_W'(r_pause_time)) begin
                        n_step    = (r_step == STEP_ONE) ? STEP_TWO :
                                    (r_step == STEP_ZERO) ? STEP_ONE : STEP_ZERO;
                        n_blinks  = '0;
                        n_phase   = PH_ON;
                        n_elapsed = '0;
                        n_led     = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ON;
            r_elapsed <= '0;
            r_blinks  <= '0;
            r_step    <= STEP_ZERO;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_blinks  <= n_blinks;
            r_step    <= n_step;
        end
    end

    // The result of a transaction is the state it leaves behind.
    assign o_result.led_on      = n_led;
    assign o_result.phase_now   = n_phase;
    assign o_result.group_step  = n_step;
    assign o_result.blinks_done = n_blinks;

endmodule

[sv/lbcs_skid.sv]
// ----------------------------------------------------------------------------
// LED blink-code sequencer result buffer
// Output register with one skid entry so input and output stall independently.
// ----------------------------------------------------------------------------
module lbcs_skid import lbcs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_valid, r_skid_valid;
    t_result r_data, r_skid;
    logic    in_fire, out_fire;

    assign o_ready  = !r_skid_valid;
    assign in_fire  = i_valid && !r_skid_valid;
    assign out_fire = r_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_data <= r_skid;
            end
        end else if (in_fire) begin
            if (r_valid && !out_fire) begin
                r_skid <= i_data;
            end else begin
                r_data <= i_data;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[sim/tb_led_blink_count_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED blink-code sequencer testbench
// Drives tick and restart transactions through the stream port, rewrites the
// timing and blink-count registers between phases, and checks every result
// transaction against the bench's cycle-free sequencer model or a typed-in result.
// ----------------------------------------------------------------------------
module tb_led_blink_count_sequencer;
    import lbcs_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PCT     = 27;
    // Quiet period after the last expected result is taken, to be sure
    // nothing is still in flight.
    localparam int SETTLE_CYCLES = 4;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_ITEMS   = 106;
    localparam int RESTART_PCT   = 3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [TIME_W-1:0]     i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    led_blink_count_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock period.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Sequencer model: register copies and sequence state, updated at the
    // same clock edges at which the block accepts a write or a tick.
    // ------------------------------------------------------------------------
    logic [TIME_W-1:0]     seq_on_time    = RST_ON_TIME;
    logic [TIME_W-1:0]     seq_gap_time   = RST_GAP_TIME;
    logic [TIME_W-1:0]     seq_pause_time = RST_PAUSE_TIME;
    logic [COUNT_W-1:0]    seq_group_len [3] = '{RST_BLINKS_0, RST_BLINKS_1, RST_BLINKS_2};
    logic [1:0]            seq_phase   = PH_ON;
    logic [TIMER_BITS-1:0] seq_elapsed = '0;
    logic [COUNT_W-1:0]    seq_blinks  = '0;
    logic [1:0]            seq_step    = STEP_ZERO;
    logic                  seq_led     = 1'b0;

    // Advance the sequence by one tick (or restart it) and return what the
    // block should report for that transaction.
    function automatic t_result advance_blink_sequence(input logic restart);
        t_result            res;
        longint unsigned    ticks;
        logic [COUNT_W-1:0] group_len;
        if (restart) begin
            // Registers survive a restart; only the sequence clears.
            seq_phase   = PH_ON;
            seq_elapsed = '0;
            seq_blinks  = '0;
            seq_step    = STEP_ZERO;
            seq_led     = 1'b0;
        end else begin
            if (seq_elapsed != {TIMER_BITS{1'b1}}) seq_elapsed = seq_elapsed + 1'b1;
            ticks = seq_elapsed;
            case (seq_phase)
                PH_ON: begin
                    seq_led = 1'b1;
                    if (ticks >= seq_on_time) begin
                        seq_led = 1'b0;
                        if (seq_blinks != {COUNT_W{1'b1}}) seq_blinks = seq_blinks + 1'b1;
                        seq_elapsed = '0;
                        // A step code beyond the table would fall back to group zero.
                        group_len = (seq_step == STEP_ONE) ? seq_group_len[1] :
                                    (seq_step == STEP_TWO) ? seq_group_len[2] :
                                                             seq_group_len[0];
                        seq_phase = (seq_blinks >= group_len) ? PH_PAUSE : PH_GAP;
                    end
                end
                PH_GAP: begin
                    seq_led = 1'b0;
                    if (ticks >= seq_gap_time) begin
                        seq_phase   = PH_ON;
                        seq_elapsed = '0;
                        seq_led     = 1'b1;
                    end
                end
                default: begin
                    seq_led   = 1'b0;
                    seq_phase = PH_PAUSE;
                    if (ticks >= seq_pause_time) begin
                        seq_step    = (seq_step >= STEP_TWO) ? STEP_ZERO : seq_step + 1'b1;
                        seq_blinks  = '0;
                        seq_phase   = PH_ON;
                        seq_elapsed = '0;
                        seq_led     = 1'b1;
                    end
                end
            endcase
        end
        res.led_on      = seq_led;
        res.phase_now   = seq_phase;
        res.group_step  = seq_step;
        res.blinks_done = seq_blinks;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: checks each result transaction against the oldest pending
    // expectation, then records the expectation of any tick accepted at the
    // same edge. Directed rows may carry a hand-written expectation, which
    // then replaces the model's answer while the model still steps along.
    // ------------------------------------------------------------------------
    t_result pending_results[$];
    logic    row_fixed_valid = 1'b0;
    t_result row_fixed_result = '0;
    int      fail_count = 0;

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        t_result model_res;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[RES_W-1:0];
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result with nothing expected:",
                             $time, " actual led %0d phase %0d step %0d blinks %0d",
                             got.led_on, got.phase_now, got.group_step,
                             got.blinks_done);
                end else begin
                    want = pending_results.pop_front();
                    if (got.led_on !== want.led_on || got.phase_now !== want.phase_now ||
                        got.group_step !== want.group_step ||
                        got.blinks_done !== want.blinks_done) begin
                        fail_count++;
                        $display("%0t ns: mismatch:", $time,
                                 " expected led %0d phase %0d step %0d blinks %0d,",
                                 want.led_on, want.phase_now, want.group_step,
                                 want.blinks_done,
                                 " actual led %0d phase %0d step %0d blinks %0d",
                                 got.led_on, got.phase_now, got.group_step,
                                 got.blinks_done);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ON_TIME:    seq_on_time      = i_cfg_data;
                    CFG_GAP_TIME:   seq_gap_time     = i_cfg_data;
                    CFG_PAUSE_TIME: seq_pause_time   = i_cfg_data;
                    CFG_BLINKS_0:   seq_group_len[0] = i_cfg_data[COUNT_W-1:0];
                    CFG_BLINKS_1:   seq_group_len[1] = i_cfg_data[COUNT_W-1:0];
                    CFG_BLINKS_2:   seq_group_len[2] = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                model_res = advance_blink_sequence(s_axis_tdata[0]);
                pending_results.push_back(row_fixed_valid ? row_fixed_result : model_res);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink. It drops tready about 27% of the time, never while the
    // steady flag is set, and on request holds it low until hold_cycles runs
    // out, so the block's output buffer fills and its input stalls.
    // ------------------------------------------------------------------------
    logic steady_flow = 1'b0;
    int   hold_cycles = 0;

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Source side tasks. All of them are entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Offer one tick or restart transaction, optionally after a random gap.
    // tvalid is only lowered on a gap, so back-to-back transactions keep it
    // high with a single assignment per edge.
    task automatic send_tick(input logic restart, input logic has_fixed,
                             input t_result fixed);
        if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        row_fixed_valid  = has_fixed;
        row_fixed_result = fixed;
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= {{(IN_DATA_W-1){1'b0}}, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every expected result has been taken,
    // then wait out the settle period as well.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write transaction. i_cfg_valid stays high so a batch of
    // writes runs back to back; the caller lowers it after the batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_phase_time();
        int r;
        r = $urandom_range(99);
        if (r < 4) return '0;
        if (r < 6) return {TIME_W{1'b1}};
        if (r < 70) return TIME_W'($urandom_range(1, 4));
        return TIME_W'($urandom_range(5, 16));
    endfunction

    function automatic logic [TIME_W-1:0] pick_group_len();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 12) return TIME_W'({COUNT_W{1'b1}});
        if (r < 80) return TIME_W'($urandom_range(1, 4));
        return TIME_W'($urandom_range(5, 14));
    endfunction

    // ------------------------------------------------------------------------
    // Directed table: register rows and tick rows, with the result typed in
    // where it is obvious and otherwise left to the model.
    // ------------------------------------------------------------------------
    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [TIME_W-1:0]    value;
        logic                 restart;
        logic                 has_fixed;
        t_result              fixed;
    } t_directed_row;

    t_directed_row directed_rows[$];

    function automatic void add_reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [TIME_W-1:0] value);
        directed_rows.push_back('{1'b1, idx, value, 1'b0, 1'b0, t_result'(0)});
    endfunction

    function automatic void add_tick_row(input logic restart);
        directed_rows.push_back('{1'b0, '0, '0, restart, 1'b0, t_result'(0)});
    endfunction

    function automatic void add_known_row(input logic restart, input logic led,
                                          input logic [1:0] phase, input logic [1:0] step,
                                          input logic [COUNT_W-1:0] blinks);
        t_result r;
        r.led_on      = led;
        r.phase_now   = phase;
        r.group_step  = step;
        r.blinks_done = blinks;
        directed_rows.push_back('{1'b0, '0, '0, restart, 1'b1, r});
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic prev_was_reg;
        int   n_items;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // Default registers: the first tick lights the LED at once, and a
        // restart darkens it again while staying in the on phase.
        add_known_row(1'b0, 1'b1, PH_ON, STEP_ZERO, 4'd0);
        add_known_row(1'b1, 1'b0, PH_ON, STEP_ZERO, 4'd0);
        // Shortest legal timing: every phase lasts one tick, so the walk
        // through all three groups can be read off directly.
        add_reg_row(CFG_ON_TIME, 16'd1);
        add_reg_row(CFG_GAP_TIME, 16'd1);
        add_reg_row(CFG_PAUSE_TIME, 16'd1);
        add_known_row(1'b0, 1'b0, PH_PAUSE, STEP_ZERO, 4'd1);
        add_known_row(1'b0, 1'b1, PH_ON, STEP_ONE, 4'd0);
        add_known_row(1'b0, 1'b0, PH_GAP, STEP_ONE, 4'd1);
        add_known_row(1'b0, 1'b1, PH_ON, STEP_ONE, 4'd1);
        add_known_row(1'b0, 1'b0, PH_PAUSE, STEP_ONE, 4'd2);
        add_known_row(1'b0, 1'b1, PH_ON, STEP_TWO, 4'd0);
        repeat (6) add_tick_row(1'b0);
        // Zero times end each phase on its first tick; a zero blink count
        // still gives one blink; the other groups run the longest count.
        add_reg_row(CFG_ON_TIME, 16'd0);
        add_reg_row(CFG_GAP_TIME, 16'd0);
        add_reg_row(CFG_PAUSE_TIME, 16'd0);
        add_reg_row(CFG_BLINKS_0, 16'd0);
        add_reg_row(CFG_BLINKS_1, 16'd15);
        add_reg_row(CFG_BLINKS_2, 16'd15);
        add_known_row(1'b1, 1'b0, PH_ON, STEP_ZERO, 4'd0);
        repeat (5) add_tick_row(1'b0);
        // Longest times: a restart darkens the LED, then the on phase keeps it lit.
        add_reg_row(CFG_ON_TIME, 16'hFFFF);
        add_reg_row(CFG_GAP_TIME, 16'hFFFF);
        add_reg_row(CFG_PAUSE_TIME, 16'hFFFF);
        add_known_row(1'b1, 1'b0, PH_ON, STEP_ZERO, 4'd0);
        add_known_row(1'b0, 1'b1, PH_ON, STEP_ZERO, 4'd0);
        add_known_row(1'b0, 1'b1, PH_ON, STEP_ZERO, 4'd0);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register writes only go out once the block has nothing in flight.
        prev_was_reg = 1'b0;
        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                if (!prev_was_reg) wait_results_drained();
                write_reg(directed_rows[k].idx, directed_rows[k].value);
            end else begin
                if (prev_was_reg) i_cfg_valid <= 1'b0;
                send_tick(directed_rows[k].restart, directed_rows[k].has_fixed,
                          directed_rows[k].fixed);
            end
            prev_was_reg = directed_rows[k].is_cfg;
        end
        row_fixed_valid = 1'b0;

        // Random phases: fresh registers each time, then mostly ticks with the
        // odd restart. Short times keep the sequence cycling through all of
        // its phases and groups.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_results_drained();
            write_reg(CFG_ON_TIME, pick_phase_time());
            write_reg(CFG_GAP_TIME, pick_phase_time());
            write_reg(CFG_PAUSE_TIME, pick_phase_time());
            write_reg(CFG_BLINKS_0, pick_group_len());
            write_reg(CFG_BLINKS_1, pick_group_len());
            write_reg(CFG_BLINKS_2, pick_group_len());
            i_cfg_valid <= 1'b0;

            // One phase runs with no idling on either side, and in another
            // the sink holds off long enough to back the block up.
            steady_flow = (ph == 3);
            if (ph == 6) hold_cycles = 150;

            n_items = PHASE_ITEMS + $urandom_range(0, 8);
            for (int i = 0; i < n_items; i++) begin
                // Halfway through one phase the source waits for every
                // result before carrying on with the same registers.
                if (ph == 8 && i == n_items / 2) wait_results_drained();
                send_tick($urandom_range(99) < RESTART_PCT, 1'b0, t_result'(0));
            end
        end
        steady_flow = 1'b0;

        wait_results_drained();
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb_led_blink_count_sequencer: PASS");
        end else begin
            $display("tb_led_blink_count_sequencer: FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legitimate run.
    initial begin
        #5_000_000;
        $display("tb_led_blink_count_sequencer: FAIL");
        $finish;
    end

endmodule

[led_blink_count_sequencer.f]
sv/lbcs_pkg.sv
sv/lbcs_core.sv
sv/lbcs_skid.sv
sv/led_blink_count_sequencer.sv
sim/tb_led_blink_count_sequencer.sv
